@@ src/sha1_hs_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1_hs_pkg
// Shared types, constants and round functions of the streaming SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1_hs_pkg;

   localparam int unsigned BlockWords  = 16;
   localparam int unsigned ChainWords  = 5;
   localparam int unsigned RoundCount  = 80;
   localparam int unsigned LenOffset   = 56;
   localparam int unsigned BufAddrW    = $clog2(BlockWords);
   localparam int unsigned ChainAddrW  = $clog2(ChainWords);

   typedef logic [31:0] word_type;
   typedef logic [6:0]  count_type;

   localparam logic [7:0] PadMark     = 8'h80;
   localparam logic [2:0] LastWordIdx = 3'(ChainWords - 1);

   // control from the sequencer to the compression datapath
   typedef struct packed {
      logic      load_word;   // shift a block word into the schedule window
      logic      shift_vars;  // shift a chaining word into the working variables
      logic      do_round;    // run one compression round
      count_type round_num;
   } core_ctl_type;

   function automatic word_type init_word(input logic [ChainAddrW-1:0] idx);
      word_type w;
      unique case (idx)
         3'd0:    w = 32'h67452301;
         3'd1:    w = 32'hEFCDAB89;
         3'd2:    w = 32'h98BADCFE;
         3'd3:    w = 32'h10325476;
         3'd4:    w = 32'hC3D2E1F0;
         default: w = 32'h0;
      endcase
      return w;
   endfunction

   function automatic word_type round_const(input count_type t);
      word_type k;
      priority if (t < 7'd20) k = 32'h5A827999;
      else if (t < 7'd40)     k = 32'h6ED9EBA1;
      else if (t < 7'd60)     k = 32'h8F1BBCDC;
      else                    k = 32'hCA62C1D6;
      return k;
   endfunction

   function automatic word_type round_mix(input count_type t, input word_type b,
                                          input word_type c, input word_type d);
      word_type f;
      priority if (t < 7'd20) f = (b & c) | (~b & d);
      else if (t < 7'd40)     f = b ^ c ^ d;
      else if (t < 7'd60)     f = (b & c) | (b & d) | (c & d);
      else                    f = b ^ c ^ d;
      return f;
   endfunction

endpackage

@@ src/sha1_hs_req_if.sv @@
// ----------------------------------------------------------------------------
// sha1_hs_req_if
// Message byte channel: valid/ready with one byte and its flags per beat.
// ----------------------------------------------------------------------------
interface sha1_hs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

@@ src/sha1_hs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sha1_hs_rsp_if
// Digest channel: valid/ready with one digest word per beat.
// ----------------------------------------------------------------------------
interface sha1_hs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ src/sha1_hs_ram.sv @@
// ----------------------------------------------------------------------------
// sha1_hs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sha1_hs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ src/sha1_hs_core.sv @@
// ----------------------------------------------------------------------------
// sha1_hs_core
// Compression datapath: 16-word schedule window, working variables a..e,
// one round per cycle, and the chaining add used during write-back.
// ----------------------------------------------------------------------------
module sha1_hs_core (
   input  logic                     clock,
   input  sha1_hs_pkg::core_ctl_type ctl,
   input  sha1_hs_pkg::word_type     buf_word,
   input  sha1_hs_pkg::word_type     chain_word,
   output sha1_hs_pkg::word_type     fold_sum
);
   import sha1_hs_pkg::*;

   word_type sched_ff [BlockWords];
   word_type sched_in [BlockWords];
   word_type a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type a_in, b_in, c_in, d_in, e_in;
   word_type sched_mix, sched_next, mix;

   // W[t+16] from taps t+13, t+8, t+2, t
   assign sched_mix  = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
   assign sched_next = {sched_mix[30:0], sched_mix[31]};

   assign mix = {a_ff[26:0], a_ff[31:27]}
              + round_mix(ctl.round_num, b_ff, c_ff, d_ff)
              + e_ff + round_const(ctl.round_num) + sched_ff[0];

   always_comb begin
      for (int i = 0; i < BlockWords; i++) begin
         sched_in[i] = sched_ff[i];
      end
      if (ctl.load_word || ctl.do_round) begin
         for (int i = 0; i < BlockWords - 1; i++) begin
            sched_in[i] = sched_ff[i+1];
         end
         sched_in[BlockWords-1] = ctl.load_word ? buf_word : sched_next;
      end

      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      if (ctl.shift_vars) begin
         a_in = b_ff; b_in = c_ff; c_in = d_ff; d_in = e_ff; e_in = chain_word;
      end else if (ctl.do_round) begin
         a_in = mix;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   assign fold_sum = chain_word + a_ff;
endmodule

@@ src/sha1_hash_stream_unit.sv @@
// ----------------------------------------------------------------------------
// sha1_hash_stream_unit
// Streaming SHA-1 hasher: bytes in, five digest words out per message.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan carries one message byte per beat (has_byte qualifies it);
//    end_of_message closes the message after the byte of the same beat.
//  - rsp_chan returns h0..h4 as five beats, word_index 0..4, last_word on 4.
//  - While filling a block, req_chan stays ready and takes byte beats back to back.
//  - Each full 64-byte block goes through load, round and write-back steps,
//    set by the single round unit and the one read port of each memory.
//  - On end_of_message the pad bytes are pushed one per cycle between block
//    compressions (0x80, zeros, then the 8-byte length), giving one or two
//    more blocks. After the last write-back each digest word is read from
//    the chaining memory in StEmitRd, then registered from StEmitWait.
//  - A stalled rsp_chan holds its beat; a new word is fetched only once the
//    output register is free. The next message is accepted while the last
//    digest beat still waits.
//  - Reset returns the control to idle with the SHA-1 initial chaining
//    values selected; the memories need no clearing pass.
// ----------------------------------------------------------------------------
module sha1_hash_stream_unit (
   input logic          clock,
   input logic          reset,
   sha1_hs_req_if.sink   req_chan,
   sha1_hs_rsp_if.source rsp_chan
);
   import sha1_hs_pkg::*;

   typedef enum logic [6:0] {
      StIdle     = 7'b0000001,
      StPad      = 7'b0000010,
      StLoad     = 7'b0000100,
      StRound    = 7'b0001000,
      StFold     = 7'b0010000,
      StEmitRd   = 7'b0100000,
      StEmitWait = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;        // where to go after a compression
   count_type cnt_ff, cnt_in;        // load / round / fold / emit step
   logic [5:0]  fill_ff, fill_in;    // bytes in the current block
   logic [23:0] acc_ff, acc_in;      // partial big-endian word
   logic [63:0] bits_ff, bits_in;    // message length in bits
   logic fresh_ff, fresh_in;         // chaining memory not yet written this message
   logic mark_ff, mark_in;           // next pad byte is the 0x80 mark
   logic len_ff, len_in;             // length bytes being pushed
   logic [ChainAddrW-1:0] rd_idx_ff; // chaining word now on the read port

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   word_type    digest_ff, digest_in;
   logic [2:0]  widx_ff, widx_in;
   logic        last_ff, last_in;

   logic       req_fire, out_free, push_en, block_full, in_len, buf_wr_en;
   logic [7:0] push_byte, pad_byte, len_byte;
   word_type   buf_rdata, chain_rdata, chain_word, fold_sum;
   logic       chain_wr_en;
   core_ctl_type ctl;

   assign req_chan.ready = (state_ff == StIdle);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // pad byte: mark, zeros until offset 56, then the length big-endian
   assign in_len   = !mark_ff && (len_ff || fill_ff == 6'(LenOffset));
   assign len_byte = 8'(bits_ff >> {~fill_ff[2:0], 3'b000});
   assign pad_byte = mark_ff ? PadMark : (in_len ? len_byte : 8'h00);

   assign push_en    = (state_ff == StPad) || (req_fire && req_chan.has_byte);
   assign push_byte  = (state_ff == StPad) ? pad_byte : req_chan.data_byte;
   assign block_full = push_en && (&fill_ff);
   assign buf_wr_en  = push_en && (&fill_ff[1:0]);

   // fresh message: chaining reads return the initial values
   assign chain_word  = fresh_ff ? init_word(rd_idx_ff) : chain_rdata;
   assign chain_wr_en = (state_ff == StFold) && (cnt_ff != 7'd0);

   always_comb begin
      ctl.load_word  = (state_ff == StLoad) && (cnt_ff != 7'd0);
      ctl.shift_vars = ((state_ff == StLoad) || (state_ff == StFold))
                       && (cnt_ff != 7'd0) && (cnt_ff <= 7'(ChainWords));
      ctl.do_round   = (state_ff == StRound);
      ctl.round_num  = cnt_ff;
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cnt_in   = cnt_ff;
      fill_in  = push_en ? fill_ff + 6'd1 : fill_ff;
      acc_in   = push_en ? {acc_ff[15:0], push_byte} : acc_ff;
      bits_in  = bits_ff;
      fresh_in = fresh_ff;
      mark_in  = mark_ff;
      len_in   = len_ff;

      rsp_valid_in = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      digest_in    = digest_ff;
      widx_in      = widx_ff;
      last_in      = last_ff;

      unique case (state_ff)
         StIdle: begin
            if (req_fire) begin
               if (req_chan.has_byte) begin
                  bits_in = bits_ff + 64'd8;
               end
               if (req_chan.end_of_message) begin
                  mark_in = 1'b1;
               end
               if (block_full) begin
                  state_in = StLoad;
                  ret_in   = req_chan.end_of_message ? StPad : StIdle;
                  cnt_in   = '0;
               end else if (req_chan.end_of_message) begin
                  state_in = StPad;
               end
            end
         end
         StPad: begin
            mark_in = 1'b0;
            if (in_len) begin
               len_in = 1'b1;
            end
            if (block_full) begin
               state_in = StLoad;
               ret_in   = in_len ? StEmitRd : StPad;
               cnt_in   = '0;
            end
         end
         StLoad: begin
            if (cnt_ff == 7'(BlockWords)) begin
               state_in = StRound;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         StRound: begin
            if (cnt_ff == 7'(RoundCount - 1)) begin
               state_in = StFold;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         StFold: begin
            if (cnt_ff == 7'(ChainWords)) begin
               state_in = ret_ff;
               fresh_in = 1'b0;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         StEmitRd: begin
            if (out_free) begin
               state_in = StEmitWait;
            end
         end
         StEmitWait: begin
            rsp_valid_in = 1'b1;
            digest_in    = chain_rdata;
            widx_in      = cnt_ff[2:0];
            last_in      = (cnt_ff[2:0] == LastWordIdx);
            if (cnt_ff[2:0] == LastWordIdx) begin
               // next message starts from the initial values
               state_in = StIdle;
               cnt_in   = '0;
               fresh_in = 1'b1;
               bits_in  = '0;
               len_in   = 1'b0;
            end else begin
               state_in = StEmitRd;
               cnt_in   = cnt_ff + 7'd1;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         ret_ff       <= StIdle;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         bits_ff      <= '0;
         fresh_ff     <= 1'b1;
         mark_ff      <= 1'b0;
         len_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         fresh_ff     <= fresh_in;
         mark_ff      <= mark_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff    <= acc_in;
      rd_idx_ff <= cnt_ff[ChainAddrW-1:0];
      digest_ff <= digest_in;
      widx_ff   <= widx_in;
      last_ff   <= last_in;
   end

   // block buffer, one big-endian word per entry
   sha1_hs_ram #(
      .WIDTH(32),
      .DEPTH(BlockWords)
   ) u_buf_ram (
      .clock  (clock),
      .wr_en  (buf_wr_en),
      .wr_addr(fill_ff[5:2]),
      .wr_data({acc_ff, push_byte}),
      .rd_addr(cnt_ff[BufAddrW-1:0]),
      .rd_data(buf_rdata)
   );

   // chaining words h0..h4
   sha1_hs_ram #(
      .WIDTH(32),
      .DEPTH(ChainWords)
   ) u_chain_ram (
      .clock  (clock),
      .wr_en  (chain_wr_en),
      .wr_addr(rd_idx_ff),
      .wr_data(fold_sum),
      .rd_addr(cnt_ff[ChainAddrW-1:0]),
      .rd_data(chain_rdata)
   );

   sha1_hs_core u_core (
      .clock     (clock),
      .ctl       (ctl),
      .buf_word  (buf_rdata),
      .chain_word(chain_word),
      .fold_sum  (fold_sum)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.digest_word = digest_ff;
   assign rsp_chan.word_index  = widx_ff;
   assign rsp_chan.last_word   = last_ff;

   // a filled block always goes to compression next
   a_full_loads: assert property (@(posedge clock) disable iff (reset)
      block_full |=> state_ff == StLoad)
      else $error("full block not compressed");

   // a digest word is only captured into a free output register
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == StEmitWait |-> $past(out_free))
      else $error("digest beat overwritten");

   // write-back completes before any digest read
   a_fold_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == StEmitRd |-> !fresh_ff)
      else $error("digest read from initial values");

   // last flag only on the final word
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (last_ff == (widx_ff == LastWordIdx)))
      else $error("last_word misplaced");

   // length bytes end exactly at the block boundary
   a_len_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == StPad && len_ff |-> fill_ff[5:3] == 3'b111)
      else $error("length bytes misaligned");
endmodule
